### rtl/cpl_pkg.sv
// Shared types, constants and the exp2 tap function for the cutoff power law
// evaluator. No dependencies.
package cpl_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MODEL    = 3'd0,
    CFG_LOG_NORM = 3'd1,
    CFG_INDEX    = 3'd2,
    CFG_CUTOFF   = 3'd3,
    CFG_REF      = 3'd4,
    CFG_SCALE    = 3'd5
  } cfg_idx_e;

  // Model select codes
  localparam logic [1:0] MODEL_POWER_LAW = 2'd0;
  localparam logic [1:0] MODEL_CUTOFF    = 2'd1;

  // log2(10) and log2(e) in Q.24
  localparam logic [26:0] LOG2_TEN_Q24 = 27'd55732705;
  localparam logic [24:0] LOG2_E_Q24   = 25'd24204406;

  // Tap t_i of the exp2 chain: t_0 = 2^32, t_i = floor(sqrt(t_{i-1} * 2^31))
  function automatic logic [31:0] exp2_tap(input int unsigned step);
    logic [63:0] t;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] c;
    t = 64'd1 << 32;
    for (int unsigned i = 1; i <= step; i++) begin
      v = t << 31;
      r = 64'd0;
      for (int b = 31; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (c * c <= v) r = c;
      end
      t = r;
    end
    return t[31:0];
  endfunction

endpackage

### rtl/cpl_log2.sv
// 25-stage log2 pipeline for an unsigned Q24.8 value, result in Q.24.
// Stage 0 normalizes, stages 1..24 square once each. Uses no package.
module cpl_log2 (
  input  logic               clk_i,
  input  logic [24:0]        en_i,
  input  logic [31:0]        x_i,
  output logic signed [29:0] log_o
);

  logic [31:0] m_q  [0:24];
  logic [4:0]  p_q  [0:24];
  logic [23:0] fr_q [0:24];

  logic [31:0] xx;
  logic [4:0]  p0;

  // Leading one search and normalize to Q1.31
  always_comb begin
    xx = (x_i == 32'd0) ? 32'd1 : x_i;
    p0 = 5'd0;
    for (int b = 0; b < 32; b++) begin
      if (xx[b]) p0 = 5'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      m_q[0]  <= xx << (5'd31 - p0);
      p_q[0]  <= p0;
      fr_q[0] <= 24'd0;
    end
  end

  // One squaring step per stage, one fraction bit each
  for (genvar k = 1; k <= 24; k++) begin : g_sq
    logic [63:0] sq;
    assign sq = 64'(m_q[k-1]) * 64'(m_q[k-1]);
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        p_q[k] <= p_q[k-1];
        if (sq[63]) begin
          m_q[k]  <= sq[63:32];
          fr_q[k] <= {fr_q[k-1][22:0], 1'b1};
        end else begin
          m_q[k]  <= sq[62:31];
          fr_q[k] <= {fr_q[k-1][22:0], 1'b0};
        end
      end
    end
  end

  // (p - 8) * 2^24 + fraction
  assign log_o = {({1'b0, p_q[24]} - 6'd8), fr_q[24]};

endmodule

### rtl/cpl_exp2.sv
// 24-stage pipeline for 2^(f/2^24) in Q1.31, one tap multiply per stage.
// Depends on cpl_pkg for the tap constants.
module cpl_exp2 (
  input  logic        clk_i,
  input  logic [23:0] en_i,
  input  logic [23:0] f_i,
  output logic [31:0] m_o
);

  logic [31:0] m_q [0:23];
  logic [23:0] f_q [0:23];

  for (genvar k = 0; k < 24; k++) begin : g_step
    localparam logic [31:0] TAP = cpl_pkg::exp2_tap(k + 1);
    logic [31:0] m_prev;
    logic [23:0] f_prev;
    logic [63:0] prod;

    if (k == 0) begin : g_first
      assign m_prev = 32'h8000_0000;
      assign f_prev = f_i;
    end else begin : g_next
      assign m_prev = m_q[k-1];
      assign f_prev = f_q[k-1];
    end

    assign prod = 64'(m_prev) * 64'(TAP);

    // Multiply by the tap where this fraction bit is set
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        m_q[k] <= f_prev[23-k] ? prod[62:31] : m_prev;
        f_q[k] <= f_prev;
      end
    end
  end

  assign m_o = m_q[23];

endmodule

### rtl/cutoff_power_law_eval.sv
// Cutoff power law evaluator, top level: config registers, divider, sum and
// output stages. Depends on cpl_pkg, cpl_log2 and cpl_exp2.
//
// Usage:
//   Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) writes
//   one register per item; ready is always high. Write only while idle.
//   Input channel takes one energy (unsigned Q24.8) per item; output channel
//   returns is_zero, a Q1.15 mantissa and a signed base-2 exponent.
//   52 register stages lie between the input and the output. One item per
//   cycle sustained while the receiver takes every result. Depth is set
//   by the 25-stage log2 lanes (the divider, two quotient bits per stage,
//   and the ratio scaling run alongside them), the product and sum stages,
//   the 24 exp2 tap stages and the output register. Each stage holds its
//   item until the next stage has room, so a stalled receiver first fills
//   bubbles; in_ready_o drops only when every stage holds an item and the
//   output is not taken. Nothing is lost or repeated. Reset clears all
//   valid bits and loads the register defaults (power law, log_norm -11,
//   index 2, cutoff 5000, ref energy 1000, scale 0).
module cutoff_power_law_eval #(
  parameter int OUT_MANTISSA_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [2:0]                   cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [31:0]                  energy_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         is_zero_o,
  output logic [OUT_MANTISSA_BITS-1:0] mantissa_o,
  output logic signed [9:0]            exponent_o
);

  localparam int NSTG = 52;

  // Config registers
  logic [1:0]         model_q;
  logic signed [21:0] log_norm_q;
  logic signed [20:0] index_q;
  logic signed [31:0] cutoff_q;
  logic [31:0]        ref_q;
  logic signed [22:0] scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q    <= cpl_pkg::MODEL_POWER_LAW;
      log_norm_q <= -22'sd720896;
      index_q    <= 21'sd131072;
      cutoff_q   <= 32'sd1280000;
      ref_q      <= 32'd256000;
      scale_q    <= 23'sd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cpl_pkg::CFG_MODEL:    model_q    <= cfg_data_i[1:0];
        cpl_pkg::CFG_LOG_NORM: log_norm_q <= cfg_data_i[21:0];
        cpl_pkg::CFG_INDEX:    index_q    <= cfg_data_i[20:0];
        cpl_pkg::CFG_CUTOFF:   cutoff_q   <= cfg_data_i;
        cpl_pkg::CFG_REF:      ref_q      <= cfg_data_i;
        cpl_pkg::CFG_SCALE:    scale_q    <= cfg_data_i[22:0];
        default: ;
      endcase
    end
  end

  // Stage valids and per-stage advance
  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   en;

  always_comb begin
    en[NSTG] = out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NSTG-1];

  // Log2 lanes, stages 0..24
  logic signed [29:0] log_e;
  logic signed [29:0] log_r;

  cpl_log2 u_log_e (
    .clk_i (clk_i),
    .en_i  (en[24:0]),
    .x_i   (energy_i),
    .log_o (log_e)
  );

  cpl_log2 u_log_r (
    .clk_i (clk_i),
    .en_i  (en[24:0]),
    .x_i   (ref_q),
    .log_o (log_r)
  );

  // Divider: stage 0 setup, stages 1..18 two quotient bits each
  logic [31:0] e_in;
  logic [30:0] dvsr;
  logic [30:0] rem_q  [0:18];
  logic [35:0] num_q  [0:18];
  logic [35:0] quo_q  [0:18];
  logic        dovf_q [0:18];

  assign e_in = (energy_i == 32'd0) ? 32'd1 : energy_i;
  assign dvsr = cutoff_q[30:0];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rem_q[0]  <= {11'd0, e_in[31:12]};
      num_q[0]  <= {e_in[11:0], 24'd0};
      quo_q[0]  <= 36'd0;
      dovf_q[0] <= ({11'd0, e_in} >= {dvsr, 12'd0});
    end
  end

  for (genvar s = 1; s <= 18; s++) begin : g_div
    logic [31:0] t;
    logic [30:0] r;
    logic [35:0] n;
    logic [35:0] q;
    always_comb begin
      r = rem_q[s-1];
      n = num_q[s-1];
      q = quo_q[s-1];
      t = 32'd0;
      for (int j = 0; j < 2; j++) begin
        t = {r, n[35]};
        n = {n[34:0], 1'b0};
        if (t >= {1'b0, dvsr}) begin
          t = t - {1'b0, dvsr};
          q = {q[34:0], 1'b1};
        end else begin
          q = {q[34:0], 1'b0};
        end
        r = t[30:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        rem_q[s]  <= r;
        num_q[s]  <= n;
        quo_q[s]  <= q;
        dovf_q[s] <= dovf_q[s-1];
      end
    end
  end

  // Stage 19: cap ratio and scale by log2(e); stages 20..24 delay
  localparam logic [35:0] RATIO_CAP = 36'h8_0000_0000;
  logic [35:0] rcap;
  logic [60:0] cprod;
  logic [36:0] c_q [0:5];

  assign rcap  = (dovf_q[18] || quo_q[18] > RATIO_CAP) ? RATIO_CAP : quo_q[18];
  assign cprod = 61'(rcap) * 61'(cpl_pkg::LOG2_E_Q24);

  always_ff @(posedge clk_i) begin
    if (en[19]) c_q[0] <= cprod[60:24];
    for (int k = 1; k < 6; k++) begin
      if (en[19+k]) c_q[k] <= c_q[k-1];
    end
  end

  // Stage 25: index and norm products, zero flag
  logic signed [30:0] diff;
  logic signed [51:0] gprod_q;
  logic signed [48:0] aprod_q;
  logic [36:0]        c25_q;
  logic               z25_q;

  assign diff = 31'(log_r) - 31'(log_e);

  always_ff @(posedge clk_i) begin
    if (en[25]) begin
      gprod_q <= 52'(index_q) * 52'(diff);
      aprod_q <= 49'(log_norm_q) * $signed({22'd0, cpl_pkg::LOG2_TEN_Q24});
      c25_q   <= (model_q == cpl_pkg::MODEL_CUTOFF) ? c_q[5] : 37'd0;
      z25_q   <= (model_q[1]) ||
                 ((model_q == cpl_pkg::MODEL_CUTOFF) && (cutoff_q <= 32'sd0));
    end
  end

  // Stage 26: L = A - B + G - C
  logic signed [48:0] ash;
  logic signed [51:0] gsh;
  logic signed [41:0] la;
  logic signed [41:0] lb;
  logic signed [41:0] lg;
  logic signed [41:0] lc;
  logic signed [41:0] l_q;
  logic               z26_q;

  assign ash = aprod_q >>> 16;
  assign gsh = gprod_q >>> 16;
  assign la  = ash[41:0];
  assign lg  = gsh[41:0];
  assign lb  = {{11{scale_q[22]}}, scale_q, 8'd0};
  assign lc  = {5'd0, c25_q};

  always_ff @(posedge clk_i) begin
    if (en[26]) begin
      l_q   <= la - lb + lg - lc;
      z26_q <= z25_q;
    end
  end

  // Stages 27..50: exp2 of the fraction, flags travel alongside
  logic signed [17:0] exr;
  logic [31:0]        m_exp;
  logic               zf_q [0:23];
  logic               of_q [0:23];
  logic [9:0]         ex_q [0:23];

  assign exr = l_q[41:24];

  cpl_exp2 u_exp2 (
    .clk_i (clk_i),
    .en_i  (en[50:27]),
    .f_i   (l_q[23:0]),
    .m_o   (m_exp)
  );

  always_ff @(posedge clk_i) begin
    if (en[27]) begin
      zf_q[0] <= z26_q || (exr < -18'sd512);
      of_q[0] <= (exr > 18'sd511);
      ex_q[0] <= exr[9:0];
    end
    for (int k = 1; k < 24; k++) begin
      if (en[27+k]) begin
        zf_q[k] <= zf_q[k-1];
        of_q[k] <= of_q[k-1];
        ex_q[k] <= ex_q[k-1];
      end
    end
  end

  // Stage 51: output register
  always_ff @(posedge clk_i) begin
    if (en[51]) begin
      is_zero_o <= zf_q[23];
      if (zf_q[23]) begin
        mantissa_o <= '0;
        exponent_o <= 10'sd0;
      end else if (of_q[23]) begin
        mantissa_o <= '1;
        exponent_o <= 10'sd511;
      end else begin
        mantissa_o <= m_exp[31 -: OUT_MANTISSA_BITS];
        exponent_o <= ex_q[23];
      end
    end
  end

`ifndef SYNTH
  // A zero result carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_zero_o |-> mantissa_o == '0 && exponent_o == 10'sd0)
    else $error("zero result with nonzero fields");

  // A nonzero mantissa is normalized
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_zero_o |-> mantissa_o[OUT_MANTISSA_BITS-1])
    else $error("mantissa not normalized");

  // Input stalls only when the pipe is full and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && (&v_q))
    else $error("input stalled with room in the pipe");
`endif

endmodule

### bench/tb_cutoff_power_law_eval.sv
// Testbench for cutoff_power_law_eval: directed and random energies over many register
// settings, checked against a bit-exact log2-domain predictor held in a scoreboard.
// Depends on cpl_pkg and the cutoff_power_law_eval RTL.
module tb_cutoff_power_law_eval;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MANT_BITS = 16;
  localparam int DRAIN_CYCLES = 64;      // covers the pipeline depth
  localparam int STALL_LIMIT = 4000;
  localparam logic [2:0] CFG_UNUSED = 3'd6;
  localparam logic [1:0] MODEL_ZERO_A = 2'd2;
  localparam logic [1:0] MODEL_ZERO_B = 2'd3;

  typedef struct packed {
    logic                 is_zero;
    logic [MANT_BITS-1:0] mantissa;
    logic signed [9:0]    exponent;
  } spectrum_t;

  // Predicts one spectral value per accepted energy and checks results in order
  class spectrum_board;
    spectrum_t pending[$];
    int unsigned mismatches = 0;
    int unsigned checked = 0;
    int unsigned zeros = 0;
    int unsigned saturated = 0;
    logic [1:0] model = cpl_pkg::MODEL_POWER_LAW;
    longint norm_q16 = -720896;
    longint index_q16 = 131072;
    longint cutoff_q8 = 1280000;
    longint unsigned e0_q8 = 256000;
    longint scale_q16 = 0;
    longint unsigned taps[1:24];
    bit taps_ready = 0;

    function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned r, c;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    function automatic longint log2_q24(logic [31:0] x);
      int p;
      longint unsigned m;
      longint fr;
      p = 31;
      fr = 0;
      if (x == 0) x = 1;
      while (!x[p]) p--;
      m = longint'(x) << (31 - p);
      for (int i = 0; i < 24; i++) begin
        m = (m * m) >> 31;
        fr = fr << 1;
        if (m >= (64'd1 << 32)) begin
          m = m >> 1;
          fr = fr | 1;
        end
      end
      return (longint'(p) - 8) * (64'sd1 << 24) + fr;
    endfunction

    function void configure(logic [2:0] idx, logic [31:0] d);
      case (idx)
        cpl_pkg::CFG_MODEL:    model = d[1:0];
        cpl_pkg::CFG_LOG_NORM: norm_q16 = longint'($signed(d[21:0]));
        cpl_pkg::CFG_INDEX:    index_q16 = longint'($signed(d[20:0]));
        cpl_pkg::CFG_CUTOFF:   cutoff_q8 = longint'($signed(d));
        cpl_pkg::CFG_REF:      e0_q8 = longint'(d);
        cpl_pkg::CFG_SCALE:    scale_q16 = longint'($signed(d[22:0]));
        default: ;
      endcase
    endfunction

    function void note_energy(logic [31:0] e);
      spectrum_t s;
      longint a, g, c, l, ex;
      longint unsigned r, m, t;
      if (!taps_ready) begin
        t = 64'd1 << 32;
        for (int i = 1; i <= 24; i++) begin
          t = isqrt(t << 31);
          taps[i] = t;
        end
        taps_ready = 1;
      end
      s = '{is_zero: 1'b1, mantissa: '0, exponent: '0};
      if (e == 0) e = 1;
      if (model == cpl_pkg::MODEL_POWER_LAW ||
          (model == cpl_pkg::MODEL_CUTOFF && cutoff_q8 > 0)) begin
        a = (norm_q16 * 55732705) >>> 16;
        g = (index_q16 * (log2_q24(e0_q8[31:0]) - log2_q24(e))) >>> 16;
        c = 0;
        if (model == cpl_pkg::MODEL_CUTOFF) begin
          r = (longint'(e) << 24) / longint'(cutoff_q8);
          if (r > (64'd1 << 35)) r = 64'd1 << 35;
          c = longint'((r * 24204406) >> 24);
        end
        l = a - scale_q16 * 256 + g - c;
        ex = l >>> 24;
        if (ex > 511) begin
          s = '{is_zero: 1'b0, mantissa: '1, exponent: 10'sd511};
        end else if (ex >= -512) begin
          m = 64'd1 << 31;
          for (int i = 1; i <= 24; i++)
            if (l[24-i]) m = (m * taps[i]) >> 31;
          s.is_zero = 1'b0;
          s.mantissa = m[31 -: MANT_BITS];
          s.exponent = ex[9:0];
        end
      end
      pending = {pending, s};
    endfunction

    function void check_result(logic z, logic [MANT_BITS-1:0] mt, logic signed [9:0] ex);
      spectrum_t w;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result zero=%0d mant=%h exp=%0d", $realtime, z, mt, ex);
        mismatches++;
        return;
      end
      w = pending.pop_front();
      if (w.is_zero) zeros++;
      if (!w.is_zero && w.exponent == 10'sd511) saturated++;
      if (z !== w.is_zero) begin
        $display("%0t: is_zero expected %0d actual %0d", $realtime, w.is_zero, z);
        mismatches++;
      end
      if (mt !== w.mantissa) begin
        $display("%0t: mantissa expected %h actual %h", $realtime, w.mantissa, mt);
        mismatches++;
      end
      if (ex !== w.exponent) begin
        $display("%0t: exponent expected %0d actual %0d", $realtime, w.exponent, ex);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [31:0] energy_i = 32'd256;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic is_zero_o;
  logic [MANT_BITS-1:0] mantissa_o;
  logic signed [9:0] exponent_o;

  spectrum_board board = new;
  int unsigned tx_idle_pct = 31;
  int unsigned rx_idle_pct = 54;
  int unsigned energies_sent = 0;
  int unsigned phases = 0;
  int unsigned quiet_cycles = 0;

  always #10 clk_i = ~clk_i;

  cutoff_power_law_eval #(.OUT_MANTISSA_BITS(MANT_BITS)) u_dut (.*);

  // Monitor: sample handshakes at the rising edge
  always @(posedge clk_i) begin
    if (cfg_valid_i && cfg_ready_o) board.configure(cfg_index_i, cfg_data_i);
    if (in_valid_i && in_ready_o) board.note_energy(energy_i);
    if (out_valid_o && out_ready_i) board.check_result(is_zero_o, mantissa_o, exponent_o);
  end

  // Watchdog on cycles with no accepted item
  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $realtime);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver backpressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_energy(logic [31:0] e);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    energy_i <= e;
    energies_sent++;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write all registers while the pipeline is empty; optionally poke an unused index
  task automatic program_regs(logic [1:0] mdl, int nrm, int idx, logic [31:0] cut,
                              logic [31:0] e0, int scl, bit poke_unused);
    logic [31:0] vals[6];
    wait_idle();
    vals = '{32'(mdl), 32'(nrm), 32'(idx), cut, e0, 32'(scl)};
    for (int i = 0; i < 7; i++) begin
      if (i == 6 && !poke_unused) break;
      cfg_valid_i <= 1'b1;
      cfg_index_i <= (i == 6) ? CFG_UNUSED : 3'(i);
      cfg_data_i <= (i == 6) ? $urandom : vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    phases++;
  endtask

  function automatic logic [31:0] pick_energy();
    case ($urandom_range(3))
      0: return $urandom | 32'd1;
      1: return $urandom_range(32'd4096, 32'd1);
      2: return $urandom_range(32'd2560000, 32'd2560);
      default: return 32'd1 << $urandom_range(31);
    endcase
  endfunction

  initial begin
    int nrm, idx, scl, n;
    logic [31:0] cut, e0;
    logic [1:0] mdl;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset settings, field extremes
    send_energy(32'd1);
    send_energy(32'hFFFF_FFFF);
    send_energy(32'd256000);
    send_energy(32'h8000_0000);
    send_energy(32'd256);
    // Cutoff mode with tiny cutoff: ratio cap, plus an ignored register index
    program_regs(cpl_pkg::MODEL_CUTOFF, -720896, 131072, 32'd1, 32'd256000, 0, 1);
    send_energy(32'hFFFF_FFFF);
    send_energy(32'd1);
    // Negative and zero cutoff force zero
    program_regs(cpl_pkg::MODEL_CUTOFF, 0, 131072, 32'h8000_0000, 32'd256000, 0, 0);
    send_energy(32'd256000);
    program_regs(cpl_pkg::MODEL_CUTOFF, 0, 131072, 32'd0, 32'd256000, 0, 0);
    send_energy(32'd256000);
    // Unfinished modes give zero
    program_regs(MODEL_ZERO_A, 0, 0, 32'd1280000, 32'd256000, 0, 0);
    send_energy(32'd512);
    program_regs(MODEL_ZERO_B, 0, 0, 32'd1280000, 32'd256000, 0, 0);
    send_energy(32'd512);
    // Overflow and underflow extremes, zero reference energy
    program_regs(cpl_pkg::MODEL_POWER_LAW, 1310720, 524288, 32'h7FFF_FFFF, 32'd0,
                 -4194304, 0);
    send_energy(32'd1);
    send_energy(32'hFFFF_FFFF);
    program_regs(cpl_pkg::MODEL_POWER_LAW, -1310720, -524288, 32'd1280000, 32'hFFFF_FFFF,
                 4194303, 0);
    send_energy(32'd1);
    send_energy(32'hFFFF_FFFF);
    program_regs(cpl_pkg::MODEL_CUTOFF, 65536, -524288, 32'h7FFF_FFFF, 32'd1, -4194304, 0);
    send_energy(32'd1);
    send_energy(32'd300);

    // Random phases
    for (int ph = 0; ph < 12; ph++) begin
      tx_idle_pct = (ph < 4) ? 31 : (ph < 8) ? 54 : 0;
      rx_idle_pct = (ph < 4) ? 54 : (ph < 8) ? 31 : 0;
      mdl = ($urandom_range(9) < 8) ? 2'($urandom_range(1)) : 2'($urandom_range(3));
      if (ph % 2 == 0) begin
        nrm = $urandom_range(2621440) - 1310720;
        idx = $urandom_range(1048576) - 524288;
        scl = $urandom_range(8388607) - 4194304;
        cut = ($urandom_range(1)) ? $urandom : $urandom_range(32'h7FFF_FFFF, 1);
        e0 = ($urandom_range(3) == 0) ? 32'd1 : $urandom;
      end else begin
        nrm = $urandom_range(1048576) - 786432;
        idx = $urandom_range(393216) - 131072;
        scl = $urandom_range(2097152) - 1048576;
        cut = $urandom_range(32'd200000000, 32'd256);
        e0 = $urandom_range(32'd2560000, 32'd256);
      end
      program_regs(mdl, nrm, idx, cut, e0, scl, ph == 5);
      n = 96;
      for (int k = 0; k < n; k++) begin
        // Let the pipeline run dry once mid-stream
        if (ph == 9 && k == 48) wait_idle();
        send_energy(pick_energy());
      end
    end

    wait_idle();
    $display("Covered %0d energies over %0d register settings; %0d results checked,",
             energies_sent, phases, board.checked);
    $display("%0d zero and %0d saturated, %0d mismatches.",
             board.zeros, board.saturated, board.mismatches);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
